@@ src/ptt_pkg.sv @@
package ptt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam logic OP_TOGGLE = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_MISSED   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [15:0] transaction_id;
    logic [63:0] peer_addr_high;
    logic [63:0] peer_addr_low;
  } ptt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] matched_id;
    logic [63:0] saved_addr_high;
    logic [63:0] saved_addr_low;
  } ptt_out_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
    logic load_out;
  } ptt_cmd_t;

  typedef struct packed {
    logic issue_last;
  } ptt_stat_t;

endpackage

@@ src/ptt_ctrl.sv @@
module ptt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ptt_pkg::ptt_stat_t stat,
  output ptt_pkg::ptt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/ptt_dpath.sv @@
module ptt_dpath #(
  parameter int unsigned TABLE_DEPTH = ptt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptt_pkg::ptt_in_t   in_data,
  input  ptt_pkg::ptt_cmd_t  cmd,
  output ptt_pkg::ptt_stat_t stat,
  output ptt_pkg::ptt_out_t  out_data
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [15:0]            id_mem [TABLE_DEPTH];
  logic [63:0]            hi_mem [TABLE_DEPTH];
  logic [63:0]            lo_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  ptt_pkg::ptt_in_t  req_r;
  ptt_pkg::ptt_out_t out_r;

  logic [IDX_W-1:0] cnt_r;
  logic             cmp_v_r;
  logic             cmp_vld_r;
  logic [15:0]      cmp_id_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [1:0]       status_r;
  logic             tog_hit_r;
  logic [63:0]      rd_hi_r;
  logic [63:0]      rd_lo_r;

  logic do_insert;
  logic do_remove;

  assign stat.issue_last = (cnt_r == LAST_IDX);
  assign do_remove = cmd.commit && hit_r;
  assign do_insert = cmd.commit && !hit_r && (req_r.operation == ptt_pkg::OP_TOGGLE) && free_r;

  // request latch and scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_data;
    end
    if (cmd.issue) begin
      cmp_id_r  <= id_mem[cnt_r];
      cmp_vld_r <= valid_r[cnt_r];
      cmp_idx_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      cmp_v_r <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      cmp_v_r <= cmd.issue;
      if (cmd.start) begin
        cnt_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (cmd.issue && !stat.issue_last) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (cmp_v_r) begin
          if (cmp_vld_r && (cmp_id_r == req_r.transaction_id)) begin
            hit_r <= 1'b1;
          end
          if (!cmp_vld_r && !free_r) begin
            free_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_v_r && cmp_vld_r && (cmp_id_r == req_r.transaction_id)) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (cmp_v_r && !cmp_vld_r && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_remove) begin
      valid_r[hit_idx_r] <= 1'b0;
    end else if (do_insert) begin
      valid_r[free_idx_r] <= 1'b1;
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (do_insert) begin
      id_mem[free_idx_r] <= req_r.transaction_id;
      hi_mem[free_idx_r] <= req_r.peer_addr_high;
      lo_mem[free_idx_r] <= req_r.peer_addr_low;
    end
    if (do_remove) begin
      rd_hi_r <= hi_mem[hit_idx_r];
      rd_lo_r <= lo_mem[hit_idx_r];
    end
  end

  // result decision
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tog_hit_r <= hit_r && (req_r.operation == ptt_pkg::OP_TOGGLE);
      if (hit_r) begin
        status_r <= ptt_pkg::ST_REMOVED;
      end else if (req_r.operation == ptt_pkg::OP_REMOVE) begin
        status_r <= ptt_pkg::ST_MISSED;
      end else if (free_r) begin
        status_r <= ptt_pkg::ST_INSERTED;
      end else begin
        status_r <= ptt_pkg::ST_FULL;
      end
    end
    if (cmd.load_out) begin
      out_r.status          <= status_r;
      out_r.matched_id      <= tog_hit_r ? req_r.transaction_id : 16'd0;
      out_r.saved_addr_high <= tog_hit_r ? rd_hi_r : 64'd0;
      out_r.saved_addr_low  <= tog_hit_r ? rd_lo_r : 64'd0;
    end
  end

  assign out_data = out_r;

endmodule

@@ src/pending_id_toggle_table.sv @@
// a new input beat is taken only in idle, after the previous item's table scan has finished
// the next input beat is taken while a finished result waits in the output register
// reset: synchronous active-low rst_n empties the table by clearing all valid bits
// and returns the controller to idle; no clearing pass is needed
module pending_id_toggle_table #(
  parameter int unsigned TABLE_DEPTH = ptt_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptt_pkg::ptt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptt_pkg::ptt_out_t out_data
);

  ptt_pkg::ptt_cmd_t  cmd;
  ptt_pkg::ptt_stat_t stat;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
